@@ hdl/okle_pkg.sv @@
// ============================================================================
// okle_pkg: shared definitions for the ordered key list engine
// Action and status codes, cell command encodings and the key compare.
// ============================================================================
`default_nettype none

package okle_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int KEY_W  = 32;
    localparam int ACT_W  = 4;
    localparam int ST_W   = 2;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;

    // stream packing, lowest field first, padded to whole bytes
    localparam int S_DATA_W = 40;   // action, key
    localparam int M_DATA_W = 48;   // status, key_out, position, count

    // action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INS_SORT  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 4'd2;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 4'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_DEL_KEY   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_REVERSE   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_READ      = 4'd8;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    // which cells raise their mark for an insert or delete
    localparam logic [2:0] MK_ALL   = 3'd0;  // every cell (front)
    localparam logic [2:0] MK_FREE  = 3'd1;  // empty cells (back insert)
    localparam logic [2:0] MK_SORT  = 3'd2;  // empty or key >= new key
    localparam logic [2:0] MK_TAIL  = 3'd3;  // last occupied cell
    localparam logic [2:0] MK_MATCH = 3'd4;  // occupied and equal key

    typedef struct packed {
        logic [1:0]              op;
        logic [2:0]              mark;
        logic signed [KEY_W-1:0] key;
    } cell_cmd_t;

    typedef struct packed {
        logic occ;        // cell holds a stored key
        logic tail;       // cell holds the last stored key
        logic rot_right;  // rotation: take right neighbor
        logic rot_head;   // rotation: take the head key
    } cell_ctl_t;

    function automatic logic key_ge(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
        return a >= b;
    endfunction

endpackage

`default_nettype wire

@@ hdl/okle_cell.sv @@
// ============================================================================
// okle_cell: one storage cell of the key chain
// Holds one key; shifts left or right, loads a new key or rotates the head in.
// ============================================================================
`default_nettype none

module okle_cell (
    input  logic                              clk,
    input  okle_pkg::cell_cmd_t               cmd,
    input  okle_pkg::cell_ctl_t               ctl,
    input  logic signed [okle_pkg::KEY_W-1:0] left_key,
    input  logic signed [okle_pkg::KEY_W-1:0] right_key,
    input  logic signed [okle_pkg::KEY_W-1:0] head_key,
    input  logic                              p_in,
    output logic                              p_out,
    output logic signed [okle_pkg::KEY_W-1:0] key_q
);
    import okle_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    mark;

    always_comb
    begin
        case (cmd.mark)
            MK_ALL:   mark = 1'b1;
            MK_FREE:  mark = !ctl.occ;
            MK_SORT:  mark = !ctl.occ || key_ge(key_reg, cmd.key);
            MK_TAIL:  mark = ctl.tail;
            MK_MATCH: mark = ctl.occ && (key_reg == cmd.key);
            default:  mark = 1'b0;
        endcase
    end

    // mark travels down the chain: set from the first marked cell onward
    assign p_out = p_in | mark;

    always_comb
    begin
        key_next = key_reg;
        unique case (cmd.op)
            CELL_INS:
            begin
                if (p_in)
                    key_next = left_key;
                else if (mark)
                    key_next = cmd.key;
            end
            CELL_DEL:
            begin
                if (p_out)
                    key_next = right_key;
            end
            CELL_ROT:
            begin
                if (ctl.rot_right)
                    key_next = right_key;
                else if (ctl.rot_head)
                    key_next = head_key;
            end
            default: key_next = key_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q = key_reg;

endmodule

`default_nettype wire

@@ hdl/ordered_key_list_engine_unit.sv @@
// ============================================================================
// ordered_key_list_engine_unit: ordered list of signed keys in a cell chain
// Insert, delete, reverse and read-out over a row of shifting key cells.
// ============================================================================
// The list lives in a row of CAPACITY cells, entry 0 in cell 0. A mark
// ripples down the row so that insert (sorted, front, back) and delete
// (front, back, first matching key) finish in one update: every cell past the
// marked one takes its neighbor's key. An action is held in a one-entry input
// buffer and executes as soon as the output register is free, so a new
// transfer is taken in the same cycle the previous action finishes; those
// actions sustain one item per cycle while results are taken. Reverse holds
// the buffer for a start step, then rotations in which the head key rotates
// into the slot just before the part already reversed. Read-out holds it for
// a start step, then one rotation of the row per cycle unless a result must
// wait, giving one result per stored key (at most 16, the last with tlast
// set); the row ends in its original order. Each result waits in an output
// register until the downstream side takes it, and every cycle that loads a
// result stalls while that register is still full. Inserts into a full list
// answer status full; delete, reverse and read-out of an empty list answer
// status empty. Unused action codes answer status ok with no change.
// ============================================================================
`default_nettype none

module ordered_key_list_engine_unit #(
    parameter int CAPACITY = okle_pkg::DEF_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream: [3:0] action, [35:4] key, [39:36] zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [okle_pkg::S_DATA_W-1:0] s_tdata,
    // master stream: [1:0] status, [33:2] key_out, [37:34] position,
    // [42:38] count, [47:43] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [okle_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import okle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);   // count width
    localparam int IW = $clog2(CAPACITY);       // cell index width

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REV  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    // control state
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] k_reg, k_next;
    logic          in_valid_reg, in_valid_next;
    logic          out_valid_reg, out_valid_next;

    // input buffer payload
    logic [ACT_W-1:0]        act_reg, act_next;
    logic signed [KEY_W-1:0] ikey_reg, ikey_next;

    // output register payload
    logic [ST_W-1:0]         ost_reg, ost_next;
    logic signed [KEY_W-1:0] okey_reg, okey_next;
    logic [POS_W-1:0]        opos_reg, opos_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;
    logic                    olast_reg, olast_next;

    // chain signals
    cell_cmd_t               cmd;
    logic [CW-1:0]           lim;
    cell_ctl_t               ctl   [CAPACITY];
    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY:0]       pchain;

    logic load_ok;
    logic finish;
    logic empty;
    logic full;
    logic found;
    logic rd_emit;
    logic rd_last;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(CAPACITY));
    assign found   = pchain[CAPACITY];
    assign load_ok = !out_valid_reg || m_tready;
    assign rd_emit = (32'(k_reg) < MAX_RESULTS);
    assign rd_last = (32'(k_reg) == MAX_RESULTS - 1) ||
                     (32'(k_reg) + 32'd1 == 32'(count_reg));

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    assign pchain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] lkey;
        logic signed [KEY_W-1:0] rkey;

        assign ctl[i].occ       = (CW'(i) < count_reg);
        assign ctl[i].tail      = (CW'(i) == count_reg - CW'(1));
        assign ctl[i].rot_right = (CW'(i) < lim);
        assign ctl[i].rot_head  = (CW'(i) == lim);

        if (i == 0)
        begin : g_first
            assign lkey = '0;
        end
        else
        begin : g_mid
            assign lkey = cell_key[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rkey = cell_key[i];
        end
        else
        begin : g_inner
            assign rkey = cell_key[i+1];
        end

        okle_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .ctl       (ctl[i]),
            .left_key  (lkey),
            .right_key (rkey),
            .head_key  (cell_key[0]),
            .p_in      (pchain[i]),
            .p_out     (pchain[i+1]),
            .key_q     (cell_key[i])
        );
    end

    // ------------------------------------------------------------------
    // action sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        in_valid_next  = in_valid_reg;
        act_next       = act_reg;
        ikey_next      = ikey_reg;
        out_valid_next = out_valid_reg;
        ost_next       = ost_reg;
        okey_next      = okey_reg;
        opos_next      = opos_reg;
        ocnt_next      = ocnt_reg;
        olast_next     = olast_reg;

        cmd.op   = CELL_HOLD;
        cmd.mark = MK_ALL;
        cmd.key  = ikey_reg;
        lim      = count_reg - CW'(1);
        finish   = 1'b0;

        // drop the result once taken; a new load below overrides
        if (m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid_reg && load_ok)
                begin
                    finish   = 1'b1;
                    ost_next = ST_OK;
                    case (act_reg) inside
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_INS_SORT, ACT_INS_FRONT, ACT_INS_BACK:
                        begin
                            if (full)
                            begin
                                ost_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.op = CELL_INS;
                                if (act_reg == ACT_INS_SORT)
                                    cmd.mark = MK_SORT;
                                else if (act_reg == ACT_INS_FRONT)
                                    cmd.mark = MK_ALL;
                                else
                                    cmd.mark = MK_FREE;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_DEL_FRONT, ACT_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                ost_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = CELL_DEL;
                                cmd.mark   = (act_reg == ACT_DEL_FRONT) ? MK_ALL : MK_TAIL;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ACT_DEL_KEY:
                        begin
                            cmd.mark = MK_MATCH;
                            if (empty)
                            begin
                                ost_next = ST_EMPTY;
                            end
                            else if (found)
                            begin
                                cmd.op     = CELL_DEL;
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                ost_next = ST_NOTFOUND;
                            end
                        end
                        ACT_REVERSE:
                        begin
                            if (empty)
                            begin
                                ost_next = ST_EMPTY;
                            end
                            else if (count_reg != CW'(1))
                            begin
                                // hold the action; status follows the last rotation
                                finish     = 1'b0;
                                state_next = S_REV;
                                k_next     = '0;
                            end
                        end
                        ACT_READ:
                        begin
                            if (empty)
                            begin
                                ost_next = ST_EMPTY;
                            end
                            else
                            begin
                                finish     = 1'b0;
                                state_next = S_READ;
                                k_next     = '0;
                            end
                        end
                        default:
                        begin
                            ost_next = ST_OK;
                        end
                    endcase

                    if (finish)
                    begin
                        out_valid_next = 1'b1;
                        okey_next      = '0;
                        opos_next      = '0;
                        ocnt_next      = CNT_W'(count_next);
                        olast_next     = 1'b1;
                    end
                end
            end

            S_REV:
            begin
                // rotate the head into slot count-1-k
                lim = count_reg - CW'(1) - CW'(k_reg);
                if (CW'(k_reg) == count_reg - CW'(2))
                begin
                    if (load_ok)
                    begin
                        cmd.op         = CELL_ROT;
                        finish         = 1'b1;
                        state_next     = S_IDLE;
                        out_valid_next = 1'b1;
                        ost_next       = ST_OK;
                        okey_next      = '0;
                        opos_next      = '0;
                        ocnt_next      = CNT_W'(count_reg);
                        olast_next     = 1'b1;
                    end
                end
                else
                begin
                    cmd.op = CELL_ROT;
                    k_next = k_reg + IW'(1);
                end
            end

            S_READ:
            begin
                // emit the head and rotate it to the back; keep rotating
                // past the result limit so the row returns to its order
                if (!rd_emit || load_ok)
                begin
                    cmd.op = CELL_ROT;
                    if (rd_emit)
                    begin
                        out_valid_next = 1'b1;
                        ost_next       = ST_OK;
                        okey_next      = cell_key[0];
                        opos_next      = POS_W'(k_reg);
                        ocnt_next      = CNT_W'(count_reg);
                        olast_next     = rd_last;
                    end
                    if (CW'(k_reg) == count_reg - CW'(1))
                    begin
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + IW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
            in_valid_next = 1'b0;

        s_tready = !in_valid_reg || finish;

        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            act_next      = s_tdata[ACT_W-1:0];
            ikey_next     = s_tdata[ACT_W +: KEY_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        ikey_reg  <= ikey_next;
        ost_reg   <= ost_next;
        okey_reg  <= okey_next;
        opos_reg  <= opos_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {(M_DATA_W - ST_W - KEY_W - POS_W - CNT_W)'(0),
                       ocnt_reg, opos_reg, okey_reg, ost_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("stored key count exceeds capacity");

    a_busy_holds_action: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_valid_reg)
        else $error("multi-cycle action running without a held action");

    a_rev_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REV) |-> (count_reg >= CW'(2)))
        else $error("reverse running on fewer than two keys");

    a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> $stable(count_reg))
        else $error("key count changed during read-out");
`endif

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ============================================================================
// testbench: self-checking bench for the ordered key list engine
// Drives list actions over the slave stream, predicts every result with a
// behavioral copy of the list and checks each master transfer field by field.
// ============================================================================
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import okle_pkg::*;

    localparam int CAPACITY        = DEF_CAPACITY;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;

    // action codes with no function in the block
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 4'd9;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [KEY_W-1:0] key_out;
        logic [POS_W-1:0]        position;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } list_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;    // [3:0] action, [35:4] key, [39:36] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;    // [1:0] status, [33:2] key_out,
                                       // [37:34] position, [42:38] count
    logic                  m_tlast;

    // shadow copy of the list, entry 0 first
    logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
    int                      shadow_count;

    list_result_t pending_results [$];
    int           mismatch_count;
    bit           idle_on;
    bit           long_hold;

    ordered_key_list_engine_unit #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // List prediction
    // ------------------------------------------------------------------------

    task automatic push_status(input logic [ST_W-1:0] st);
        list_result_t r;
        r.status   = st;
        r.key_out  = '0;
        r.position = '0;
        r.count    = shadow_count[CNT_W-1:0];
        r.last     = 1'b1;
        pending_results.push_back(r);
    endtask

    task automatic shadow_insert(input int idx, input logic signed [KEY_W-1:0] key);
        for (int i = shadow_count; i > idx; i--)
            shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[idx] = key;
        shadow_count++;
    endtask

    task automatic shadow_remove(input int idx);
        for (int i = idx; i + 1 < shadow_count; i++)
            shadow_keys[i] = shadow_keys[i+1];
        shadow_count--;
    endtask

    // Update the shadow list for one accepted action and queue its results.
    task automatic apply_action(input logic [ACT_W-1:0] act,
                                input logic signed [KEY_W-1:0] key);
        int                      idx;
        int                      n;
        logic [ST_W-1:0]         st;
        logic signed [KEY_W-1:0] tmp;
        list_result_t            r;
        st = ST_OK;
        case (act)
            ACT_CLEAR:
                shadow_count = 0;
            ACT_INS_SORT, ACT_INS_FRONT, ACT_INS_BACK:
            begin
                if (shadow_count >= CAPACITY)
                    st = ST_FULL;
                else if (act == ACT_INS_SORT)
                begin
                    // place before the first stored key >= new key
                    idx = 0;
                    while (idx < shadow_count && shadow_keys[idx] < key)
                        idx++;
                    shadow_insert(idx, key);
                end
                else if (act == ACT_INS_FRONT)
                    shadow_insert(0, key);
                else
                    shadow_insert(shadow_count, key);
            end
            ACT_DEL_FRONT, ACT_DEL_BACK:
            begin
                if (shadow_count == 0)
                    st = ST_EMPTY;
                else
                    shadow_remove(act == ACT_DEL_FRONT ? 0 : shadow_count - 1);
            end
            ACT_DEL_KEY:
            begin
                if (shadow_count == 0)
                    st = ST_EMPTY;
                else
                begin
                    idx = 0;
                    while (idx < shadow_count && shadow_keys[idx] != key)
                        idx++;
                    if (idx < shadow_count)
                        shadow_remove(idx);
                    else
                        st = ST_NOTFOUND;
                end
            end
            ACT_REVERSE:
            begin
                if (shadow_count == 0)
                    st = ST_EMPTY;
                else
                    for (int i = 0; i < shadow_count / 2; i++)
                    begin
                        tmp = shadow_keys[i];
                        shadow_keys[i] = shadow_keys[shadow_count-1-i];
                        shadow_keys[shadow_count-1-i] = tmp;
                    end
            end
            ACT_READ:
            begin
                if (shadow_count == 0)
                    st = ST_EMPTY;
            end
            default:
                ;
        endcase

        if (act == ACT_READ && shadow_count > 0)
        begin
            // one transfer per entry, tlast on the final one
            n = shadow_count < MAX_RESULTS ? shadow_count : MAX_RESULTS;
            for (int i = 0; i < n; i++)
            begin
                r.status   = ST_OK;
                r.key_out  = shadow_keys[i];
                r.position = i[POS_W-1:0];
                r.count    = shadow_count[CNT_W-1:0];
                r.last     = (i + 1 == n);
                pending_results.push_back(r);
            end
        end
        else
            push_status(st);
    endtask

    // ------------------------------------------------------------------------
    // Sender: one transfer per call, with random gaps while idling is on
    // ------------------------------------------------------------------------

    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic signed [KEY_W-1:0] key);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, key, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_action(act, key);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold on request
    // ------------------------------------------------------------------------

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [KEY_W-1:0] exp_val,
                               input logic [KEY_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual %0h last %0b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("status",   exp_r.status,   m_tdata[1:0]);
                check_field("key_out",  exp_r.key_out,  m_tdata[33:2]);
                check_field("position", exp_r.position, m_tdata[37:34]);
                check_field("count",    exp_r.count,    m_tdata[42:38]);
                check_field("last",     exp_r.last,     m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Favor small values so sorted inserts collide and key deletes hit.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel < 4)
            return $urandom_range(0, 6) - 3;
        else if (sel == 4)
            return 32'sh8000_0000;
        else if (sel == 5)
            return 32'sh7fff_ffff;
        else
            return $urandom;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_stored_or_new();
        if (shadow_count > 0 && $urandom_range(0, 2) != 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        else
            return pick_key();
    endfunction

    // One random action; fill mode grows the list, drain mode shrinks it.
    task automatic send_random(input bit filling);
        int                      r;
        logic [ACT_W-1:0]        act;
        logic signed [KEY_W-1:0] key;
        r   = $urandom_range(0, 99);
        key = pick_key();
        if (filling)
        begin
            if (r < 45)       act = ACT_INS_SORT;
            else if (r < 55)  act = ACT_INS_FRONT;
            else if (r < 65)  act = ACT_INS_BACK;
            else if (r < 74)  act = ACT_READ;
            else if (r < 80)  act = ACT_REVERSE;
            else if (r < 88)  act = ACT_DEL_KEY;
            else if (r < 91)  act = ACT_DEL_FRONT;
            else if (r < 94)  act = ACT_DEL_BACK;
            else if (r < 96)  act = ACT_CLEAR;
            else              act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        else
        begin
            if (r < 6)        act = ACT_INS_SORT;
            else if (r < 10)  act = ACT_INS_BACK;
            else if (r < 28)  act = ACT_DEL_FRONT;
            else if (r < 44)  act = ACT_DEL_BACK;
            else if (r < 66)  act = ACT_DEL_KEY;
            else if (r < 78)  act = ACT_READ;
            else if (r < 88)  act = ACT_REVERSE;
            else if (r < 91)  act = ACT_CLEAR;
            else if (r < 95)  act = ACT_INS_FRONT;
            else              act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        if (act == ACT_DEL_KEY)
            key = pick_stored_or_new();
        send_item(act, key);
    endtask

    // Random walk between full and empty so both boundaries are hit often.
    task automatic run_random(input int n_items);
        bit filling;
        filling = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (filling && shadow_count == CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && shadow_count == 0 && $urandom_range(0, 1) == 0)
                filling = 1'b1;
            send_random(filling);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_empty_list();
        send_item(ACT_READ,      32'sd0);
        send_item(ACT_REVERSE,   32'sd0);
        send_item(ACT_DEL_FRONT, 32'sd0);
        send_item(ACT_DEL_BACK,  32'sd0);
        send_item(ACT_DEL_KEY,   32'sd5);
        send_item(ACT_SPARE_LO,  32'sh7fff_ffff);
        send_item(ACT_SPARE_HI,  32'sh8000_0000);
    endtask

    task automatic test_ordering();
        send_item(ACT_INS_SORT,  32'sd5);
        send_item(ACT_INS_SORT,  -32'sd7);
        send_item(ACT_INS_SORT,  32'sh7fff_ffff);
        send_item(ACT_INS_SORT,  32'sh8000_0000);
        send_item(ACT_INS_SORT,  32'sd5);
        send_item(ACT_INS_FRONT, 32'sd100);
        send_item(ACT_INS_BACK,  -32'sd1);
        send_item(ACT_READ,      32'sd0);
        send_item(ACT_REVERSE,   32'sd0);
        send_item(ACT_READ,      32'sd0);
        send_item(ACT_DEL_KEY,   32'sd5);
        send_item(ACT_DEL_KEY,   32'sd6);
        send_item(ACT_DEL_FRONT, 32'sd0);
        send_item(ACT_DEL_BACK,  32'sd0);
        send_item(ACT_CLEAR,     32'sd0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < CAPACITY; i++)
            send_item(ACT_INS_BACK, pick_key());
        send_item(ACT_INS_SORT,  32'sd0);
        send_item(ACT_INS_FRONT, 32'sh7fff_ffff);
        send_item(ACT_INS_BACK,  32'sh8000_0000);
        send_item(ACT_READ,      32'sd0);
        send_item(ACT_REVERSE,   32'sd0);
        send_item(ACT_READ,      32'sd0);
    endtask

    // Hold the receiver off while offering reads and inserts back to back.
    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            if (i % 3 == 0)
                send_item(ACT_READ, 32'sd0);
            else
                send_item(ACT_INS_SORT, pick_key());
        end
    endtask

    task automatic test_random_ops();
        run_random(230);
    endtask

    // Last stretch: no gaps on either side.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_random(100);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        shadow_count   = 0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        long_hold      = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_keys[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_ordering();
        test_full_list();
        test_backpressure();
        test_random_ops();
        test_steady_stream();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
